// ----- design/byte_ring_buffer_with_mark_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef BYTE_RING_BUFFER_WITH_MARK_UNIT_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_MARK_UNIT_DEFINES_SVH

// clocked assertion, off while reset is high
`define BRBM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define BRBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/brbm_pkg.sv -----
// shared types and constants for the byte ring buffer with mark
package brbm_pkg;

   localparam int DEPTH = 1024;             // ring slots, power of two
   localparam int PTR_W = $clog2(DEPTH);

   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int OFF_W    = 10;
   localparam int SEL_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 10;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MARK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POKE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

   localparam logic [SEL_W-1:0] SEL_HEAD = 2'd0;
   localparam logic [SEL_W-1:0] SEL_MARK = 2'd1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // control from the pointer unit to the store and result registers
   typedef struct packed {
      logic                mem_we;
      logic [PTR_W-1:0]    mem_addr;
      logic                data_sel;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    ready_count;
      logic [CNT_W-1:0]    pending_count;
      logic                is_empty;
      logic                is_full;
   } ptr_ctl_type;

endpackage

// ----- design/brbm_ptrs.sv -----
// head, tail and mark pointers with the per-command decode
module brbm_ptrs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [brbm_pkg::CMD_W-1:0]    cmd,
   input  logic [brbm_pkg::OFF_W-1:0]    offset,
   input  logic [brbm_pkg::SEL_W-1:0]    base_sel,
   output brbm_pkg::ptr_ctl_type         ctl
);
   import brbm_pkg::*;

   logic [PTR_W-1:0] wr_ff, rd_ff, mk_ff;
   logic [PTR_W-1:0] wr_in, rd_in, mk_in;
   logic [PTR_W-1:0] wr_inc, rd_inc, base, slot;
   logic [PTR_W-1:0] ready_diff, pending_diff;
   logic             full_now, empty_now;

   assign wr_inc    = wr_ff + PTR_W'(1);
   assign rd_inc    = rd_ff + PTR_W'(1);
   assign full_now  = (wr_inc == rd_ff);
   assign empty_now = (wr_ff == rd_ff);

   always_comb begin
      case (base_sel)
         SEL_HEAD: base = wr_ff;
         SEL_MARK: base = mk_ff;
         default:  base = rd_ff;
      endcase
   end

   // offset taken modulo the ring size
   assign slot = base + PTR_W'(offset);

   always_comb begin
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      mk_in        = mk_ff;
      ctl.mem_we   = 1'b0;
      ctl.mem_addr = slot;
      ctl.data_sel = 1'b0;
      ctl.status   = ST_DONE;
      unique case (cmd)
         CMD_PUSH: begin
            ctl.mem_addr = wr_ff;
            if (full_now) begin
               ctl.status = ST_FULL;
            end else begin
               ctl.mem_we = 1'b1;
               wr_in      = wr_inc;
            end
         end
         CMD_POP: begin
            ctl.mem_addr = rd_ff;
            if (empty_now) begin
               ctl.status = ST_EMPTY;
            end else begin
               ctl.data_sel = 1'b1;
               rd_in        = rd_inc;
            end
         end
         CMD_MARK:  mk_in = wr_ff;
         CMD_PEEK:  ctl.data_sel = 1'b1;
         CMD_POKE:  ctl.mem_we = 1'b1;
         CMD_CLEAR: begin
            wr_in = '0;
            rd_in = '0;
            mk_in = '0;
         end
         default: ;
      endcase

      // status after the command
      ready_diff        = mk_in - rd_in;
      pending_diff      = wr_in - mk_in;
      ctl.ready_count   = CNT_W'(ready_diff);
      ctl.pending_count = CNT_W'(pending_diff);
      ctl.is_empty      = (wr_in == rd_in);
      ctl.is_full       = ((wr_in + PTR_W'(1)) == rd_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         mk_ff <= '0;
      end else if (accept) begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         mk_ff <= mk_in;
      end
   end

endmodule

// ----- design/byte_ring_buffer_with_mark_unit.sv -----
// top level of the byte ring buffer with commit mark
//
// command channel: drive req_cmd, req_data_in, req_offset and req_base_sel
// with start; a command is taken at a rising edge where start is high and
// busy is low. commands: push, pop, mark, peek, poke, clear pointers.
// result channel: rsp_valid is high for exactly one cycle, the cycle after
// the command was taken, with the byte read (pop or peek, else zero), the
// status code and the ready/pending counts and empty/full flags as they
// stand after the command. the receiver cannot stall; every result must be
// taken in the cycle it is shown.
// one command is taken every clock cycle while busy is low: pointer
// update, ring access and status all finish in the accept cycle,
// limited by the one read/write port of the ring memory.
// reset: pointers go to zero and the ring is swept to zero one slot per
// cycle, every slot once; busy stays high during the sweep and
// no command is taken until it ends.
module byte_ring_buffer_with_mark_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [brbm_pkg::CMD_W-1:0]       req_cmd,
   input  logic [brbm_pkg::BYTE_W-1:0]      req_data_in,
   input  logic [brbm_pkg::OFF_W-1:0]       req_offset,
   input  logic [brbm_pkg::SEL_W-1:0]       req_base_sel,
   output logic                             rsp_valid,
   output logic [brbm_pkg::BYTE_W-1:0]      rsp_data_out,
   output logic [brbm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [brbm_pkg::CNT_W-1:0]       rsp_ready_count,
   output logic [brbm_pkg::CNT_W-1:0]       rsp_pending_count,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full
);
   import brbm_pkg::*;

   // ring storage, one read/write port
   logic [BYTE_W-1:0] ring_mem [DEPTH];

   logic              accept;
   ptr_ctl_type       ctl;

   // clear sweep after reset
   logic              clearing_ff;
   logic [PTR_W-1:0]  clr_addr_ff;

   // result registers
   logic                valid_ff;
   logic [BYTE_W-1:0]   rdata_ff;
   logic                data_sel_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0]    ready_ff;
   logic [CNT_W-1:0]    pending_ff;
   logic                empty_ff;
   logic                full_ff;

   assign busy   = clearing_ff;
   assign accept = start && !clearing_ff;

   brbm_ptrs u_ptrs (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_cmd),
      .offset   (req_offset),
      .base_sel (req_base_sel),
      .ctl      (ctl)
   );

   // sweep walks every slot once, then opens the command port
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + PTR_W'(1);
         if (clr_addr_ff == PTR_W'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ring write and registered read; the sweep owns the port while busy
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         ring_mem[clr_addr_ff] <= '0;
      end else if (accept && ctl.mem_we) begin
         ring_mem[ctl.mem_addr] <= req_data_in;
      end
      if (accept) begin
         rdata_ff <= ring_mem[ctl.mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   // result payload captured with the command
   always_ff @(posedge clock) begin
      if (accept) begin
         data_sel_ff <= ctl.data_sel;
         status_ff   <= ctl.status;
         ready_ff    <= ctl.ready_count;
         pending_ff  <= ctl.pending_count;
         empty_ff    <= ctl.is_empty;
         full_ff     <= ctl.is_full;
      end
   end

   assign rsp_valid         = valid_ff;
   // byte only for a pop that moved the tail or a peek
   assign rsp_data_out      = data_sel_ff ? rdata_ff : '0;
   assign rsp_status        = status_ff;
   assign rsp_ready_count   = ready_ff;
   assign rsp_pending_count = pending_ff;
   assign rsp_is_empty      = empty_ff;
   assign rsp_is_full       = full_ff;

endmodule

// ----- design/brbm_checker.sv -----
// port-level checks for the byte ring buffer with mark, bound to the top level
`include "byte_ring_buffer_with_mark_unit_defines.svh"

module brbm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [brbm_pkg::BYTE_W-1:0]   rsp_data_out,
   input logic [brbm_pkg::STATUS_W-1:0] rsp_status,
   input logic [brbm_pkg::CNT_W-1:0]    rsp_ready_count,
   input logic [brbm_pkg::CNT_W-1:0]    rsp_pending_count,
   input logic                          rsp_is_empty,
   input logic                          rsp_is_full
);
   import brbm_pkg::*;

   logic [CNT_W-1:0] total_count;
   assign total_count = rsp_ready_count + rsp_pending_count;

   // one result for each command taken, in the cycle after it
   `BRBM_ASSERT(a_result_follows, clock, reset, (rsp_valid == $past(start && !busy)), "result strobe does not match a taken command")

   // ring sweep runs right after reset
   `BRBM_ASSERT_ALWAYS(a_sweep_after_reset, clock, ($fell(reset) |-> busy), "busy low right after reset")

   // ready plus pending spans head to tail, so a zero sum must match the empty flag
   `BRBM_ASSERT(a_counts_vs_empty, clock, reset, (rsp_valid |-> (rsp_is_empty == (total_count == '0))), "empty flag disagrees with counts")

   // refused push leaves the ring full and returns no byte
   `BRBM_ASSERT(a_full_refusal, clock, reset, ((rsp_valid && rsp_status == ST_FULL) |-> (rsp_is_full && rsp_data_out == '0)), "push refusal without full ring")

   // pop on empty leaves the ring empty and returns no byte
   `BRBM_ASSERT(a_empty_pop, clock, reset, ((rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_is_empty && rsp_data_out == '0)), "empty pop without empty ring")

endmodule

bind byte_ring_buffer_with_mark_unit brbm_checker u_brbm_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_data_out      (rsp_data_out),
   .rsp_status        (rsp_status),
   .rsp_ready_count   (rsp_ready_count),
   .rsp_pending_count (rsp_pending_count),
   .rsp_is_empty      (rsp_is_empty),
   .rsp_is_full       (rsp_is_full)
);
